>>> sv/chs_pkg.sv
// chs_pkg: request and status codes and field widths of the chained hash set.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package chs_pkg;

  localparam int KEY_W = 31;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> sv/chs_if.sv
// chs_req_if / chs_rsp_if: valid-ready channels for requests and statuses.
// Depends on chs_pkg for the payload types.
`default_nettype none

interface chs_req_if;
  logic                      valid;
  logic                      ready;
  chs_pkg::req_t             req_type;
  logic [chs_pkg::KEY_W-1:0] key;
  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface chs_rsp_if;
  logic             valid;
  logic             ready;
  chs_pkg::status_t status;
  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

`default_nettype wire

>>> sv/chained_hash_set_top.sv
// Chained hash set: bucket heads, node keys, node links and node flags in
// on-chip memories. Depends on chs_pkg and the channel interfaces in chs_if.
//
// Usage
//   req: one request (search, add, remove, clear) with a 31-bit key.
//   rsp: one status per request, in request order.
//   cfg_we / cfg_wdata: writes the bucket count (0 acts as 1, values above
//   NUM_BUCKETS act as NUM_BUCKETS); write it only while the block is idle.
// Timing
//   One request at a time. A lookup first takes the key modulo the bucket
//   count in the bit-serial division unit (S_DIV), fetches the bucket head
//   (S_HRD, S_HEAD), walks the chain one node per cycle (one node memory
//   read each), then updates and posts the status (S_ACT, S_FIN).
//   An add that misses then scans the node-flag memory from the lowest
//   possibly free node, reading then checking each flag (S_ARD, S_ACHK).
//   A clear sweeps the head and flag memories.
// Reset
//   rst runs the same sweep; req.ready stays low until it ends.
// Stall
//   A status waits in the output register until rsp.ready; a new request is
//   accepted meanwhile, and its status waits until the register frees up.
`default_nettype none

module chained_hash_set_top #(
  parameter int NUM_BUCKETS = 64,
  parameter int POOL_NODES  = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [chs_pkg::CFG_W-1:0] cfg_wdata,
  chs_req_if.sink                        req,
  chs_rsp_if.source                      rsp
);

  localparam int KW     = chs_pkg::KEY_W;
  localparam int PTR_W  = $clog2(POOL_NODES + 1);
  localparam int IDX_W  = $clog2(POOL_NODES);
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CW     = $clog2(NUM_BUCKETS + 1);
  localparam int SWEEP  = (NUM_BUCKETS > POOL_NODES) ? NUM_BUCKETS : POOL_NODES;
  localparam int SW_W   = $clog2(SWEEP);
  localparam int DC_W   = $clog2(KW);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_DIV  = 10'b0000000100,
    S_HRD  = 10'b0000001000,
    S_HEAD = 10'b0000010000,
    S_WALK = 10'b0000100000,
    S_ACT  = 10'b0001000000,
    S_ARD  = 10'b0010000000,
    S_ACHK = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  // memories
  logic [PTR_W-1:0] heads_mem [NUM_BUCKETS];
  logic [KW-1:0]    keys_mem  [POOL_NODES];
  logic [PTR_W-1:0] links_mem [POOL_NODES];
  logic             used_mem  [POOL_NODES];

  state_t                state;
  logic [chs_pkg::CFG_W-1:0] bucket_count;
  chs_pkg::req_t         req_q;
  logic [KW-1:0]         key_q;
  logic [KW-1:0]         div_sh;
  logic [DC_W-1:0]       div_cnt;
  logic [CW-1:0]         rem;
  logic [PTR_W-1:0]      cur, prev, nlink, head, hint, scan;
  logic                  hit;
  logic [SW_W-1:0]       sweep;
  logic                  clr_resp;
  chs_pkg::status_t      st;
  logic                  rsp_valid;
  chs_pkg::status_t      rsp_status;

  // registered read data
  logic [PTR_W-1:0]      hd_rd;
  logic [KW-1:0]         key_rd;
  logic [PTR_W-1:0]      lk_rd;
  logic                  used_rd;

  // write port controls
  logic                  hd_we, lk_we, key_we, used_we;
  logic [BKT_W-1:0]      hd_wa;
  logic [PTR_W-1:0]      hd_wd, lk_wd;
  logic [IDX_W-1:0]      lk_wa, used_wa;
  logic                  used_wd;
  logic [IDX_W-1:0]      node_ra;

  logic [CW-1:0]         bc_eff;
  logic [CW:0]           trial;
  logic [CW-1:0]         rem_next;
  logic                  sweep_hd, sweep_node;

  // effective divisor
  always_comb begin
    if (bucket_count == '0) begin
      bc_eff = CW'(1);
    end else if (32'(bucket_count) > 32'(NUM_BUCKETS)) begin
      bc_eff = CW'(NUM_BUCKETS);
    end else begin
      bc_eff = CW'(bucket_count);
    end
  end

  // one restoring-division step
  always_comb begin
    trial = {rem, div_sh[KW-1]};
    if (trial >= {1'b0, bc_eff}) begin
      rem_next = CW'(trial - {1'b0, bc_eff});
    end else begin
      rem_next = trial[CW-1:0];
    end
  end

  assign sweep_hd   = 32'(sweep) < 32'(NUM_BUCKETS);
  assign sweep_node = 32'(sweep) < 32'(POOL_NODES);
  assign node_ra    = (state == S_HEAD) ? hd_rd[IDX_W-1:0] : lk_rd[IDX_W-1:0];

  // memory write selection
  always_comb begin
    hd_we   = 1'b0;
    hd_wa   = rem[BKT_W-1:0];
    hd_wd   = NIL;
    lk_we   = 1'b0;
    lk_wa   = scan[IDX_W-1:0];
    lk_wd   = head;
    key_we  = 1'b0;
    used_we = 1'b0;
    used_wa = scan[IDX_W-1:0];
    used_wd = 1'b0;
    unique case (state)
      S_CLR: begin
        hd_we   = sweep_hd;
        hd_wa   = sweep[BKT_W-1:0];
        used_we = sweep_node;
        used_wa = sweep[IDX_W-1:0];
      end
      S_ACT: begin
        if (req_q == chs_pkg::REQ_REMOVE && hit) begin
          used_we = 1'b1;
          used_wa = cur[IDX_W-1:0];
          if (prev == NIL) begin
            hd_we = 1'b1;
            hd_wd = nlink;
          end else begin
            lk_we = 1'b1;
            lk_wa = prev[IDX_W-1:0];
            lk_wd = nlink;
          end
        end
      end
      S_ACHK: begin
        if (!used_rd) begin
          hd_we   = 1'b1;
          hd_wd   = scan;
          lk_we   = 1'b1;
          key_we  = 1'b1;
          used_we = 1'b1;
          used_wd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // head memory
  always_ff @(posedge clk) begin
    if (hd_we) heads_mem[hd_wa] <= hd_wd;
    hd_rd <= heads_mem[rem[BKT_W-1:0]];
  end

  // node key and link memories
  always_ff @(posedge clk) begin
    if (key_we) keys_mem[scan[IDX_W-1:0]] <= key_q;
    key_rd <= keys_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (lk_we) links_mem[lk_wa] <= lk_wd;
    lk_rd <= links_mem[node_ra];
  end

  // node in-use flags
  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rd <= used_mem[scan[IDX_W-1:0]];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= chs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      sweep     <= '0;
      clr_resp  <= 1'b0;
      hint      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // S_FIN handles the output register itself
      if (rsp_valid && rsp.ready && state != S_FIN) rsp_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          if (sweep == SW_W'(SWEEP - 1)) begin
            hint  <= '0;
            st    <= chs_pkg::ST_DONE;
            state <= clr_resp ? S_FIN : S_IDLE;
          end
          sweep <= sweep + 1'b1;
        end
        S_IDLE: begin
          if (req.valid) begin
            req_q   <= req.req_type;
            key_q   <= req.key;
            div_sh  <= req.key;
            div_cnt <= '0;
            rem     <= '0;
            if (req.req_type == chs_pkg::REQ_CLEAR) begin
              sweep    <= '0;
              clr_resp <= 1'b1;
              state    <= S_CLR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          div_sh  <= {div_sh[KW-2:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DC_W'(KW - 1)) state <= S_HRD;
        end
        S_HRD: state <= S_HEAD;
        S_HEAD: begin
          head <= hd_rd;
          cur  <= hd_rd;
          prev <= NIL;
          hit  <= 1'b0;
          state <= (hd_rd == NIL) ? S_ACT : S_WALK;
        end
        S_WALK: begin
          if (key_rd == key_q) begin
            hit   <= 1'b1;
            nlink <= lk_rd;
            state <= S_ACT;
          end else begin
            prev <= cur;
            cur  <= lk_rd;
            if (lk_rd == NIL) state <= S_ACT;
          end
        end
        S_ACT: begin
          state <= S_FIN;
          case (req_q)
            chs_pkg::REQ_SEARCH: st <= hit ? chs_pkg::ST_DONE : chs_pkg::ST_ABSENT;
            chs_pkg::REQ_ADD: begin
              if (hit) begin
                st <= chs_pkg::ST_PRESENT;
              end else if (hint == NIL) begin
                st <= chs_pkg::ST_FULL;
              end else begin
                scan  <= hint;
                state <= S_ARD;
              end
            end
            default: begin
              st <= hit ? chs_pkg::ST_DONE : chs_pkg::ST_ABSENT;
              if (hit && cur < hint) hint <= cur;
            end
          endcase
        end
        S_ARD: state <= S_ACHK;
        S_ACHK: begin
          if (!used_rd) begin
            hint  <= scan + 1'b1;
            st    <= chs_pkg::ST_DONE;
            state <= S_FIN;
          end else if (scan == PTR_W'(POOL_NODES - 1)) begin
            hint  <= NIL;
            st    <= chs_pkg::ST_FULL;
            state <= S_FIN;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_ARD;
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= st;
            clr_resp   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;

endmodule

`default_nettype wire

>>> sv/chs_checker.sv
// chs_checker: port-level assertions for chained_hash_set_top, and its bind.
// Depends on chs_pkg and the top level's interface ports.
`default_nettype none

module chs_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire chs_pkg::status_t rsp_status
);

  // a stalled status stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("status dropped while stalled");

  // a stalled status keeps its value
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status))
    else $error("status changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // no status can appear the cycle after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("status too early");

endmodule

bind chained_hash_set_top chs_checker u_chs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status)
);

`default_nettype wire
